// ----- sv/hewd_pkg.sv -----
`default_nettype none

package hewd_pkg;

  // Header and SRID layout of an EWKB string
  localparam int unsigned HeaderLen   = 5;
  localparam int unsigned HdrIdxW     = $clog2(HeaderLen);
  localparam int unsigned ByteIdxW    = 4;
  localparam logic [ByteIdxW-1:0] HdrLastIdx = ByteIdxW'(HeaderLen - 1);
  localparam logic [ByteIdxW-1:0] SridEnd    = ByteIdxW'(9);
  localparam logic [7:0]          SridFlag   = 8'h20;
  localparam logic [3:0]          HexAlphaAdj = 4'd9;

  // One result item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_geometry;
    logic       srid_stripped;
  } result_t;

  // Map one ASCII character to its nibble; anything but a hex digit gives 0
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'h0;
    if (c inside {[8'h30:8'h39]}) begin
      n = c[3:0];
    end else if ((c inside {[8'h41:8'h46]}) || (c inside {[8'h61:8'h66]})) begin
      n = c[3:0] + HexAlphaAdj;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- sv/hex_ewkb_to_wkb_decoder.sv -----
// Past the header, a result item enters the two-entry output queue when its completing character is accepted.
// Header bytes are held until the fifth or the string's last byte is accepted, then leave the
// header registers one per cycle while the queue is not full. One character is taken per cycle
// unless the header drain, once per geometry string, or a full output queue stalls input.
// Reset (rst_ni, async, active low) clears the nibble, index, strip, drain and output queue state.
`default_nettype none

module hex_ewkb_to_wkb_decoder (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [7:0] hex_char_i,
  input  wire        last_char_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       has_byte_o,
  output logic       end_of_geometry_o,
  output logic       srid_stripped_o
);

  localparam int unsigned HdrIdxW = hewd_pkg::HdrIdxW;

  // Decode state
  logic [3:0]                    high_nibble_q;
  logic                          pending_q;
  logic [hewd_pkg::ByteIdxW-1:0] byte_index_q;
  logic                          strip_q;
  logic [7:0]                    hdr_q [hewd_pkg::HeaderLen];

  // Header drain state
  logic               burst_q;
  logic [HdrIdxW-1:0] burst_idx_q;
  logic [HdrIdxW-1:0] burst_last_q;
  logic               burst_end_q;
  logic               burst_strip_q;

  logic              fifo_full;
  logic              in_acc;
  logic [3:0]        nib;
  logic              completes;
  logic [7:0]        byte_val;
  logic              in_header;
  logic              hdr_done;
  logic              flag_pos1;
  logic              srid_flag;
  logic              in_push;
  hewd_pkg::result_t in_res;
  logic              start_burst;
  logic [HdrIdxW-1:0] burst_last_d;
  logic              push;
  hewd_pkg::result_t push_data;
  hewd_pkg::result_t out_res;

  assign in_stall_o = burst_q || fifo_full;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Nibble pairing and per-item result selection
  always_comb begin
    nib       = hewd_pkg::hex_nibble(hex_char_i);
    completes = pending_q || last_char_i;
    byte_val  = pending_q ? {high_nibble_q, nib} : {nib, 4'h0};
    in_header = (byte_index_q <= hewd_pkg::HdrLastIdx);
    hdr_done  = (byte_index_q == hewd_pkg::HdrLastIdx);
    flag_pos1 = (hdr_q[0] == 8'h00);
    srid_flag = |((flag_pos1 ? hdr_q[1] : byte_val) & hewd_pkg::SridFlag);

    in_push      = 1'b0;
    in_res       = '{data_byte: byte_val, has_byte: 1'b1,
                     end_of_geometry: last_char_i, srid_stripped: strip_q};
    start_burst  = 1'b0;
    burst_last_d = byte_index_q[HdrIdxW-1:0];

    if (completes) begin
      if (in_header) begin
        start_burst = hdr_done || last_char_i;
      end else if ((byte_index_q < hewd_pkg::SridEnd) && strip_q) begin
        // SRID byte: drop it, send an end marker if the string stops here
        in_push = last_char_i;
        in_res  = '{data_byte: 8'h00, has_byte: 1'b0,
                    end_of_geometry: 1'b1, srid_stripped: strip_q};
      end else begin
        in_push = 1'b1;
      end
    end
  end

  // Drain held header bytes first, otherwise forward the item's own result
  always_comb begin
    if (burst_q) begin
      push      = !fifo_full;
      push_data = '{data_byte: hdr_q[burst_idx_q], has_byte: 1'b1,
                    end_of_geometry: burst_end_q && (burst_idx_q == burst_last_q),
                    srid_stripped: burst_strip_q};
    end else begin
      push      = in_acc && in_push;
      push_data = in_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_nibble_q <= 4'h0;
      pending_q     <= 1'b0;
      byte_index_q  <= '0;
      strip_q       <= 1'b0;
      burst_q       <= 1'b0;
      burst_idx_q   <= '0;
      burst_last_q  <= '0;
      burst_end_q   <= 1'b0;
      burst_strip_q <= 1'b0;
    end else begin
      // Advance the drain, stop after the last held byte
      if (burst_q && !fifo_full) begin
        burst_idx_q <= burst_idx_q + HdrIdxW'(1);
        if (burst_idx_q == burst_last_q) begin
          burst_q <= 1'b0;
        end
      end

      if (in_acc) begin
        if (!completes) begin
          high_nibble_q <= nib;
          pending_q     <= 1'b1;
        end else begin
          pending_q <= 1'b0;
          if (start_burst) begin
            burst_q       <= 1'b1;
            burst_idx_q   <= '0;
            burst_last_q  <= burst_last_d;
            burst_end_q   <= last_char_i;
            burst_strip_q <= hdr_done && srid_flag;
          end
          if (last_char_i) begin
            // End of string: back to the start state
            high_nibble_q <= 4'h0;
            byte_index_q  <= '0;
            strip_q       <= 1'b0;
          end else begin
            if (byte_index_q < hewd_pkg::SridEnd) begin
              byte_index_q <= byte_index_q + hewd_pkg::ByteIdxW'(1);
            end
            if (hdr_done && srid_flag) begin
              strip_q <= 1'b1;
            end
          end
        end
      end
    end
  end

  // Hold the header bytes, clearing the SRID flag where it was found
  always_ff @(posedge clk_i) begin
    if (in_acc && completes && in_header) begin
      if (hdr_done && srid_flag && !flag_pos1) begin
        hdr_q[byte_index_q[HdrIdxW-1:0]] <= byte_val & ~hewd_pkg::SridFlag;
      end else begin
        hdr_q[byte_index_q[HdrIdxW-1:0]] <= byte_val;
      end
      if (hdr_done && srid_flag && flag_pos1) begin
        hdr_q[1] <= hdr_q[1] & ~hewd_pkg::SridFlag;
      end
    end
  end

  hewd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign data_byte_o       = out_res.data_byte;
  assign has_byte_o        = out_res.has_byte;
  assign end_of_geometry_o = out_res.end_of_geometry;
  assign srid_stripped_o   = out_res.srid_stripped;

endmodule

`default_nettype wire

// ----- sv/hewd_out_fifo.sv -----
`default_nettype none

module hewd_out_fifo (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  hewd_pkg::result_t      push_data_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output hewd_pkg::result_t      out_data_o
);

  hewd_pkg::result_t slot0_q, slot1_q;
  logic [1:0]        count_q, count_d;
  logic              pop;
  logic [1:0]        count_after_pop;

  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = slot0_q;
  assign full_o      = (count_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;

  // Occupancy after this cycle's pop and push
  always_comb begin
    count_after_pop = count_q - {1'b0, pop};
    count_d         = count_after_pop + {1'b0, push_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // Shift the tail forward on pop, write the pushed item behind what remains
  always_ff @(posedge clk_i) begin
    if (pop && (count_q == 2'd2)) begin
      slot0_q <= slot1_q;
    end
    if (push_i) begin
      if (count_after_pop == 2'd0) begin
        slot0_q <= push_data_i;
      end else begin
        slot1_q <= push_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/hewd_checker.sv -----
`default_nettype none

module hewd_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire [7:0] data_byte_o,
  input wire       has_byte_o,
  input wire       end_of_geometry_o,
  input wire       srid_stripped_o
);

  // A stalled result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item withdrawn while stalled");

  // A stalled result item keeps its byte
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(data_byte_o))
    else $error("result byte changed while stalled");

  // An end marker without a byte only closes a geometry
  a_marker_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> end_of_geometry_o)
    else $error("byteless item without end of geometry");

  // An end marker only follows a stripped SRID and carries a zero byte
  a_marker_srid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> srid_stripped_o && (data_byte_o == 8'h00))
    else $error("byteless item outside a stripped SRID");

  // Nothing comes out in the cycle after reset is released
  a_reset_empty: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result item offered straight out of reset");

endmodule

bind hex_ewkb_to_wkb_decoder hewd_checker u_hewd_checker (.*);

`default_nettype wire
